// ===== hw/rtl/sodd_pkg.sv =====
// Shared types, constants and register codes for the still orientation dwell detector.
// Used by the channel interfaces, the pipeline stages and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sodd_pkg;

  localparam int TIME_W  = 48;
  localparam int AXIS_W  = 16;
  localparam int SQ_W    = 31;
  localparam int SUM_W   = 32;
  localparam int LIMIT_W = 32;
  localparam int THR_W   = 15;
  localparam int DWELL_W = 32;
  localparam int POSE_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR_THR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL      = 2'd3;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] GYRO_LIMIT_RST = 32'd511055;
  localparam logic [THR_W-1:0]   MAJOR_THR_RST  = 15'd8192;
  localparam logic [THR_W-1:0]   MINOR_THR_RST  = 15'd2048;
  localparam logic [DWELL_W-1:0] DWELL_RST      = 32'd2000000;

  // Target pose codes; the remaining codes are undefined.
  localparam logic [POSE_W-1:0] POSE_NEG_Z = 3'd0;
  localparam logic [POSE_W-1:0] POSE_POS_Z = 3'd1;
  localparam logic [POSE_W-1:0] POSE_NEG_Y = 3'd2;
  localparam logic [POSE_W-1:0] POSE_POS_Y = 3'd3;
  localparam logic [POSE_W-1:0] POSE_NEG_X = 3'd4;
  localparam logic [POSE_W-1:0] POSE_POS_X = 3'd5;

  typedef struct packed {
    logic [LIMIT_W-1:0] gyro_limit_squared;
    logic [THR_W-1:0]   major_axis_threshold;
    logic [THR_W-1:0]   minor_axis_threshold;
    logic [DWELL_W-1:0] dwell_us;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]        time_us;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] rate_x;
    logic signed [AXIS_W-1:0] rate_y;
    logic signed [AXIS_W-1:0] rate_z;
    logic [POSE_W-1:0]        target_pose;
  } sample_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic [SQ_W-1:0]   sq_z;
    logic              pose_ok;
    logic              pose_undef;
  } feat_t;

  typedef struct packed {
    logic pose_held;
    logic moving;
  } result_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic out_load;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sodd_if.sv =====
// Valid/ready channel interfaces for the sample and result streams.
// Depends on sodd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sodd_sample_if;
  logic                                valid;
  logic                                ready;
  logic [sodd_pkg::TIME_W-1:0]         time_us;
  logic signed [sodd_pkg::AXIS_W-1:0]  accel_x;
  logic signed [sodd_pkg::AXIS_W-1:0]  accel_y;
  logic signed [sodd_pkg::AXIS_W-1:0]  accel_z;
  logic signed [sodd_pkg::AXIS_W-1:0]  rate_x;
  logic signed [sodd_pkg::AXIS_W-1:0]  rate_y;
  logic signed [sodd_pkg::AXIS_W-1:0]  rate_z;
  logic [sodd_pkg::POSE_W-1:0]         target_pose;

  modport source (output valid, time_us, accel_x, accel_y, accel_z,
                  rate_x, rate_y, rate_z, target_pose, input ready);
  modport sink (input valid, time_us, accel_x, accel_y, accel_z,
                rate_x, rate_y, rate_z, target_pose, output ready);
endinterface

interface sodd_result_if;
  logic valid;
  logic ready;
  logic pose_held;
  logic moving;

  modport source (output valid, pose_held, moving, input ready);
  modport sink (input valid, pose_held, moving, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/still_orientation_dwell_detector_top.sv =====
// A sample passes the capture, feature and result registers in order. Throughput: one
// sample per cycle while the result side takes results; the dwell timer feedback
// closes inside the last stage.
// Reset (rst, synchronous, active high) empties the pipeline, clears the dwell
// timer and loads the configuration registers with their default values.
// Depends on sodd_pkg, sodd_if, sodd_front and sodd_decide.
`timescale 1ns / 1ps
`default_nettype none

module still_orientation_dwell_detector_top (
  input  logic                                clk,
  input  logic                                rst,
  sodd_sample_if.sink                         sample,
  sodd_result_if.source                       result,
  input  logic                                cfg_we,
  input  logic [sodd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sodd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // The pipeline has three registers. The first captures the sample, the
  // second holds the squared rates and the pose test, and the third is the
  // result register. Each register loads when it is empty or when its
  // content moves on in the same cycle, so a sample can be taken while an
  // earlier result is still waiting for its transfer.

  sodd_pkg::cfg_t      cfg;
  sodd_pkg::pipe_ctl_t ctl;
  sodd_pkg::sample_t   sample_in;
  sodd_pkg::feat_t     feat;
  sodd_pkg::result_t   res;

  logic s1_valid, s2_valid, out_valid;
  logic out_free, s2_free, s1_free;

  // Configuration writes land directly in the register selected by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_limit_squared   <= sodd_pkg::GYRO_LIMIT_RST;
      cfg.major_axis_threshold <= sodd_pkg::MAJOR_THR_RST;
      cfg.minor_axis_threshold <= sodd_pkg::MINOR_THR_RST;
      cfg.dwell_us             <= sodd_pkg::DWELL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sodd_pkg::CFG_GYRO_LIMIT: cfg.gyro_limit_squared <= cfg_data;
        sodd_pkg::CFG_MAJOR_THR:
          cfg.major_axis_threshold <= cfg_data[sodd_pkg::THR_W-1:0];
        sodd_pkg::CFG_MINOR_THR:
          cfg.minor_axis_threshold <= cfg_data[sodd_pkg::THR_W-1:0];
        sodd_pkg::CFG_DWELL: cfg.dwell_us <= cfg_data;
      endcase
    end
  end

  // A stage is free when it is empty or when its item moves forward now.
  always_comb begin
    out_free = !out_valid || result.ready;
    s2_free  = !s2_valid || out_free;
    s1_free  = !s1_valid || s2_free;

    ctl.out_load = s2_valid && out_free;
    ctl.s2_load  = s1_valid && s2_free;
    ctl.s1_load  = sample.valid && s1_free;
  end

  assign sample.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.s1_load) begin
        s1_valid <= 1'b1;
      end else if (ctl.s2_load) begin
        s1_valid <= 1'b0;
      end
      if (ctl.s2_load) begin
        s2_valid <= 1'b1;
      end else if (ctl.out_load) begin
        s2_valid <= 1'b0;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sample_in.time_us     = sample.time_us;
    sample_in.accel_x     = sample.accel_x;
    sample_in.accel_y     = sample.accel_y;
    sample_in.accel_z     = sample.accel_z;
    sample_in.rate_x      = sample.rate_x;
    sample_in.rate_y      = sample.rate_y;
    sample_in.rate_z      = sample.rate_z;
    sample_in.target_pose = sample.target_pose;
  end

  sodd_front u_front (
    .clk       (clk),
    .ctl       (ctl),
    .cfg       (cfg),
    .sample_in (sample_in),
    .feat      (feat)
  );

  // The dwell timer advances once per item, as it enters the result register,
  // so the next item in the pipeline always sees the updated start time.
  sodd_decide u_decide (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cfg    (cfg),
    .feat   (feat),
    .result (res)
  );

  assign result.valid     = out_valid;
  assign result.pose_held = res.pose_held;
  assign result.moving    = res.moving;

  // A moving item never reports a held pose.
  a_held_excl_moving: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.pose_held && res.moving))
    else $error("pose_held and moving both set");

  // A transferred sample is in the first stage on the next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> s1_valid)
    else $error("accepted sample lost");

  // An item in the first stage stays there until it moves forward.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !ctl.s2_load) |=> s1_valid)
    else $error("first stage item dropped");

  // With a stalled result and a full pipeline no new sample is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready && s2_valid && s1_valid) |-> !sample.ready)
    else $error("sample taken into a full pipeline");

endmodule

`default_nettype wire

// ===== hw/rtl/sodd_front.sv =====
// First two pipeline registers: sample capture, then rate squares and pose test.
// Depends on sodd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sodd_front (
  input  logic                clk,
  input  sodd_pkg::pipe_ctl_t ctl,
  input  sodd_pkg::cfg_t      cfg,
  input  sodd_pkg::sample_t   sample_in,
  output sodd_pkg::feat_t     feat
);

  sodd_pkg::sample_t s1;
  sodd_pkg::feat_t   feat_next;

  logic signed [2*sodd_pkg::AXIS_W-1:0] prod_x, prod_y, prod_z;
  logic signed [sodd_pkg::AXIS_W:0] ax, ay, az, major, minor;
  logic pos_x, pos_y, pos_z, neg_x, neg_y, neg_z, sml_x, sml_y, sml_z;

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      s1 <= sample_in;
    end
    if (ctl.s2_load) begin
      feat <= feat_next;
    end
  end

  // Signed compares on 17 bits so that the negated threshold and the
  // magnitude of the most negative code are exact.
  function automatic logic signed [sodd_pkg::AXIS_W:0] abs17(
    input logic signed [sodd_pkg::AXIS_W:0] v
  );
    return v[sodd_pkg::AXIS_W] ? -v : v;
  endfunction

  always_comb begin
    prod_x = s1.rate_x * s1.rate_x;
    prod_y = s1.rate_y * s1.rate_y;
    prod_z = s1.rate_z * s1.rate_z;

    ax = {s1.accel_x[sodd_pkg::AXIS_W-1], s1.accel_x};
    ay = {s1.accel_y[sodd_pkg::AXIS_W-1], s1.accel_y};
    az = {s1.accel_z[sodd_pkg::AXIS_W-1], s1.accel_z};
    major = {2'b00, cfg.major_axis_threshold};
    minor = {2'b00, cfg.minor_axis_threshold};

    pos_x = ax > major;
    pos_y = ay > major;
    pos_z = az > major;
    neg_x = ax < -major;
    neg_y = ay < -major;
    neg_z = az < -major;
    sml_x = abs17(ax) < minor;
    sml_y = abs17(ay) < minor;
    sml_z = abs17(az) < minor;

    feat_next.time_us    = s1.time_us;
    feat_next.sq_x       = prod_x[sodd_pkg::SQ_W-1:0];
    feat_next.sq_y       = prod_y[sodd_pkg::SQ_W-1:0];
    feat_next.sq_z       = prod_z[sodd_pkg::SQ_W-1:0];
    feat_next.pose_undef = 1'b0;

    unique case (s1.target_pose)
      sodd_pkg::POSE_NEG_Z: feat_next.pose_ok = neg_z && sml_x && sml_y;
      sodd_pkg::POSE_POS_Z: feat_next.pose_ok = pos_z && sml_x && sml_y;
      sodd_pkg::POSE_NEG_Y: feat_next.pose_ok = neg_y && sml_x && sml_z;
      sodd_pkg::POSE_POS_Y: feat_next.pose_ok = pos_y && sml_x && sml_z;
      sodd_pkg::POSE_NEG_X: feat_next.pose_ok = neg_x && sml_y && sml_z;
      sodd_pkg::POSE_POS_X: feat_next.pose_ok = pos_x && sml_y && sml_z;
      default: begin
        feat_next.pose_ok    = 1'b0;
        feat_next.pose_undef = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sodd_decide.sv =====
// Last stage: rate limit, dwell timer state and the registered result.
// Depends on sodd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sodd_decide (
  input  logic                clk,
  input  logic                rst,
  input  sodd_pkg::pipe_ctl_t ctl,
  input  sodd_pkg::cfg_t      cfg,
  input  sodd_pkg::feat_t     feat,
  output sodd_pkg::result_t   result
);

  logic [sodd_pkg::TIME_W-1:0] dwell_start;
  logic                        start_seen;
  logic [sodd_pkg::TIME_W-1:0] dwell_start_next;
  logic [sodd_pkg::TIME_W-1:0] start_eff;
  logic [sodd_pkg::TIME_W-1:0] elapsed;
  logic [sodd_pkg::SUM_W-1:0]  rate_sum;
  sodd_pkg::result_t           result_next;

  always_comb begin
    rate_sum = {1'b0, feat.sq_x} + {1'b0, feat.sq_y} + {1'b0, feat.sq_z};
    // The first item starts the timer at its own time stamp.
    start_eff = start_seen ? dwell_start : feat.time_us;
    elapsed   = feat.time_us - start_eff;

    result_next.pose_held = 1'b0;
    result_next.moving    = 1'b0;
    dwell_start_next      = start_eff;

    priority if (rate_sum > cfg.gyro_limit_squared) begin
      result_next.moving = 1'b1;
      dwell_start_next   = feat.time_us;
    end else if (feat.pose_undef) begin
      dwell_start_next = start_eff;
    end else if (!feat.pose_ok) begin
      dwell_start_next = feat.time_us;
    end else if (elapsed > {{(sodd_pkg::TIME_W-sodd_pkg::DWELL_W){1'b0}}, cfg.dwell_us}) begin
      result_next.pose_held = 1'b1;
      dwell_start_next      = feat.time_us;
    end else begin
      dwell_start_next = start_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_start <= '0;
      start_seen  <= 1'b0;
    end else if (ctl.out_load) begin
      dwell_start <= dwell_start_next;
      start_seen  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_still_orientation_dwell_detector_top.sv =====
// Self-checking testbench for still_orientation_dwell_detector_top.
// Needs sodd_pkg, the sodd_if channel interfaces and the detector RTL. It keeps its
// own model of the dwell timer and the pose tests and checks every result in order.
`timescale 1ns / 1ps

module tb_still_orientation_dwell_detector_top;
  import sodd_pkg::*;

  // Pose codes 6 and 7 have no meaning; the detector must report neither
  // a held pose nor touch the dwell timer for them.
  localparam logic [POSE_W-1:0] POSE_UNDEF_A = 3'd6;
  localparam logic [POSE_W-1:0] POSE_UNDEF_B = 3'd7;

  // Accelerometer axis slots used by the pose model.
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          MAX_REPORTS = 10;

  // Families of random samples. Most are well formed for the pose of the
  // current run, so the dwell timer gets a chance to expire.
  typedef enum int {
    SK_STILL,
    SK_EDGE,
    SK_MOVING,
    SK_UNDEF,
    SK_NOISE
  } sample_kind_e;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sodd_sample_if sample_ch();
  sodd_result_if result_ch();

  still_orientation_dwell_detector_top dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // The testbench's copy of the configuration registers. They only change
  // while the detector is idle, inside apply_config.
  logic [LIMIT_W-1:0] lim_gyro  = GYRO_LIMIT_RST;
  logic [THR_W-1:0]   thr_major = MAJOR_THR_RST;
  logic [THR_W-1:0]   thr_minor = MINOR_THR_RST;
  logic [DWELL_W-1:0] dwell_lim = DWELL_RST;

  // Dwell timer state as the detector should hold it.
  logic [TIME_W-1:0] dwell_start = '0;
  bit                start_seen  = 1'b0;

  result_t           verdict_q[$];
  int unsigned       verdict_errors = 0;

  // Timestamp of the next sample to be built; advanced by the tests.
  logic [TIME_W-1:0] stamp = '0;

  // Idling switch for both sides and the output stall requests. The ready
  // process owns the stall counter; the tests only bump hold_requests.
  bit                gaps_on = 1'b1;
  int unsigned       hold_requests = 0;

  // Maps a pose code to the axis that must point along gravity and the sign
  // that axis must carry. Codes outside the six poses come back as unknown.
  function automatic void pose_axis(input logic [POSE_W-1:0] code, output int axis,
                                    output bit plus, output bit known);
    axis = AXIS_Z;
    plus = 1'b0;
    known = 1'b1;
    case (code)
      POSE_NEG_Z: axis = AXIS_Z;
      POSE_POS_Z: begin
        axis = AXIS_Z;
        plus = 1'b1;
      end
      POSE_NEG_Y: axis = AXIS_Y;
      POSE_POS_Y: begin
        axis = AXIS_Y;
        plus = 1'b1;
      end
      POSE_NEG_X: axis = AXIS_X;
      POSE_POS_X: begin
        axis = AXIS_X;
        plus = 1'b1;
      end
      default: known = 1'b0;
    endcase
  endfunction

  // Works out the verdict for one accepted sample and moves the dwell timer
  // the way the detector must: the first sample seeds the timer, too much
  // rotation or a failed pose test restarts it, and an expired dwell both
  // reports the held pose and restarts it.
  function automatic result_t judge_sample(input sample_t s);
    result_t           r;
    longint            rate_sq;
    int                acc[3];
    int                axis;
    int                major;
    int                minor;
    int                mag;
    bit                plus;
    bit                known;
    bit                ok;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    if (!start_seen) begin
      dwell_start = s.time_us;
      start_seen = 1'b1;
    end
    rate_sq = longint'($signed(s.rate_x)) * longint'($signed(s.rate_x))
            + longint'($signed(s.rate_y)) * longint'($signed(s.rate_y))
            + longint'($signed(s.rate_z)) * longint'($signed(s.rate_z));
    if (rate_sq > longint'({32'd0, lim_gyro})) begin
      dwell_start = s.time_us;
      r.moving = 1'b1;
      return r;
    end
    pose_axis(s.target_pose, axis, plus, known);
    if (!known)
      return r;
    acc[AXIS_X] = $signed(s.accel_x);
    acc[AXIS_Y] = $signed(s.accel_y);
    acc[AXIS_Z] = $signed(s.accel_z);
    major = thr_major;
    minor = thr_minor;
    ok = plus ? (acc[axis] > major) : (acc[axis] < -major);
    for (int i = 0; i < 3; i++) begin
      mag = acc[i] < 0 ? -acc[i] : acc[i];
      if (i != axis && mag >= minor)
        ok = 1'b0;
    end
    if (ok) begin
      // The subtraction stays 48 bits wide, so it wraps with the timestamp.
      elapsed = s.time_us - dwell_start;
      if (elapsed > {16'd0, dwell_lim}) begin
        dwell_start = s.time_us;
        r.pose_held = 1'b1;
      end
    end else begin
      dwell_start = s.time_us;
    end
    return r;
  endfunction

  // A sample that sits cleanly in the given pose at full scale, with no
  // rotation. Tests then bend single fields of it.
  function automatic sample_t posed_sample(input logic [POSE_W-1:0] code,
                                           input logic [TIME_W-1:0] t);
    sample_t s;
    int      axis;
    bit      plus;
    bit      known;
    s = '0;
    pose_axis(code, axis, plus, known);
    case (axis)
      AXIS_X: s.accel_x = plus ? 16'sd32767 : -16'sd32768;
      AXIS_Y: s.accel_y = plus ? 16'sd32767 : -16'sd32768;
      default: s.accel_z = plus ? 16'sd32767 : -16'sd32768;
    endcase
    s.target_pose = code;
    s.time_us = t;
    return s;
  endfunction

  // Builds a random sample for the given pose. Well-formed samples clear the
  // major threshold by a random margin and keep the other two axes inside the
  // minor bound; the other kinds break one rule on purpose.
  function automatic sample_t random_sample(input logic [POSE_W-1:0] code,
                                            input sample_kind_e kind);
    sample_t s;
    int      v[3];
    int      r[3];
    int      axis;
    int      mag;
    bit      plus;
    bit      known;
    bit      no_spin;
    s = '0;
    pose_axis(code, axis, plus, known);
    no_spin = ($urandom_range(4) == 0);
    for (int i = 0; i < 3; i++) begin
      v[i] = (thr_minor == 0) ? 0 : $urandom_range(int'(thr_minor) - 1, 0);
      if ($urandom_range(1))
        v[i] = -v[i];
      r[i] = no_spin ? 0 : $urandom_range(400, 0);
      if ($urandom_range(1))
        r[i] = -r[i];
    end
    mag = int'(thr_major) + 1 + $urandom_range(12000, 0);
    if (plus)
      v[axis] = mag > 32767 ? 32767 : mag;
    else
      v[axis] = mag > 32768 ? -32768 : -mag;
    case (kind)
      SK_EDGE: begin
        // Land exactly on a threshold, which must count as a failed pose.
        case ($urandom_range(2))
          0: v[axis] = plus ? int'(thr_major) : -int'(thr_major);
          1: v[(axis + 1) % 3] = thr_minor;
          default: v[(axis + 2) % 3] = -int'(thr_minor);
        endcase
      end
      SK_MOVING: begin
        for (int i = 0; i < 3; i++)
          r[i] = $signed(16'($urandom));
      end
      default: ;
    endcase
    s.accel_x = 16'(v[AXIS_X]);
    s.accel_y = 16'(v[AXIS_Y]);
    s.accel_z = 16'(v[AXIS_Z]);
    s.rate_x = 16'(r[0]);
    s.rate_y = 16'(r[1]);
    s.rate_z = 16'(r[2]);
    s.target_pose = code;
    if (kind == SK_UNDEF)
      s.target_pose = $urandom_range(1) ? POSE_UNDEF_A : POSE_UNDEF_B;
    if (kind == SK_NOISE) begin
      s.accel_x = 16'($urandom);
      s.accel_y = 16'($urandom);
      s.accel_z = 16'($urandom);
      s.rate_x = 16'($urandom);
      s.rate_y = 16'($urandom);
      s.rate_z = 16'($urandom);
      s.target_pose = 3'($urandom_range(7, 0));
    end
    return s;
  endfunction

  task automatic drive_payload(input sample_t s);
    sample_ch.time_us <= s.time_us;
    sample_ch.accel_x <= s.accel_x;
    sample_ch.accel_y <= s.accel_y;
    sample_ch.accel_z <= s.accel_z;
    sample_ch.rate_x <= s.rate_x;
    sample_ch.rate_y <= s.rate_y;
    sample_ch.rate_z <= s.rate_z;
    sample_ch.target_pose <= s.target_pose;
  endtask

  // Offers one sample and returns at the clock edge where it transferred.
  // Valid is never dropped and raised again within one time step: either an
  // idle cycle lowers it, or the new sample keeps it high.
  task automatic send_sample(input sample_t s);
    while (gaps_on && $urandom_range(99) < 26) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    drive_payload(s);
    do
      @(posedge clk);
    while (!sample_ch.ready);
  endtask

  // Stops offering samples and waits until every verdict has come back,
  // then lets the pipeline settle. The first edge lets the checker record
  // a sample that transferred at the edge this task was called on.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers, one per cycle, while the detector is idle.
  task automatic apply_config(input logic [LIMIT_W-1:0] limit,
                              input logic [THR_W-1:0] major,
                              input logic [THR_W-1:0] minor,
                              input logic [DWELL_W-1:0] dwell);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    idx = '{CFG_GYRO_LIMIT, CFG_MAJOR_THR, CFG_MINOR_THR, CFG_DWELL};
    val = '{limit, {17'd0, major}, {17'd0, minor}, dwell};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    lim_gyro = limit;
    thr_major = major;
    thr_minor = minor;
    dwell_lim = dwell;
  endtask

  // Runs of samples that share a target pose, with random content and
  // random time steps up to max_step. A few samples jump to a random
  // timestamp so every time bit toggles and the wrap is exercised.
  task automatic run_pose_sequences(input int n_items, input int unsigned max_step);
    sample_t               s;
    sample_kind_e          kind;
    logic [POSE_W-1:0]     code;
    int                    sent;
    int                    run_len;
    int                    roll;
    sent = 0;
    while (sent < n_items) begin
      code = 3'($urandom_range(POSE_POS_X, POSE_NEG_Z));
      run_len = $urandom_range(10, 2);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        roll = $urandom_range(99);
        if (roll < 62)
          kind = SK_STILL;
        else if (roll < 74)
          kind = SK_EDGE;
        else if (roll < 84)
          kind = SK_MOVING;
        else if (roll < 92)
          kind = SK_UNDEF;
        else
          kind = SK_NOISE;
        if ($urandom_range(99) < 5)
          stamp = {16'($urandom), 32'($urandom)};
        else
          stamp = stamp + $urandom_range(max_step, 0);
        s = random_sample(code, kind);
        s.time_us = stamp;
        send_sample(s);
        sent++;
      end
    end
  endtask

  // The very first sample seeds the timer, so it cannot report a held pose.
  // Then the dwell boundary: equal to the dwell is not enough, one more is.
  task automatic test_dwell_from_first_sample();
    stamp = 48'd1000;
    send_sample(posed_sample(POSE_POS_Z, stamp));
    stamp = stamp + DWELL_RST;
    send_sample(posed_sample(POSE_POS_Z, stamp));
    stamp = stamp + 1;
    send_sample(posed_sample(POSE_POS_Z, stamp));
  endtask

  // Every pose once, with the vertical axis at its most extreme code and the
  // two others just inside the minor bound.
  task automatic test_each_pose_at_full_scale();
    sample_t           s;
    logic [POSE_W-1:0] codes[6];
    codes = '{POSE_NEG_Z, POSE_POS_Z, POSE_NEG_Y, POSE_POS_Y, POSE_NEG_X, POSE_POS_X};
    foreach (codes[i]) begin
      stamp = stamp + DWELL_RST + 1;
      s = posed_sample(codes[i], stamp);
      if (codes[i] == POSE_NEG_Z || codes[i] == POSE_POS_Z) begin
        s.accel_x = 16'sd2047;
        s.accel_y = -16'sd2047;
      end else if (codes[i] == POSE_NEG_Y || codes[i] == POSE_POS_Y) begin
        s.accel_x = -16'sd2047;
        s.accel_z = 16'sd2047;
      end else begin
        s.accel_y = 16'sd2047;
        s.accel_z = -16'sd2047;
      end
      send_sample(s);
    end
  endtask

  // Values that sit exactly on a threshold fail, one step inside passes.
  task automatic test_threshold_edges();
    sample_t s;
    stamp = stamp + 10;
    s = posed_sample(POSE_POS_Y, stamp);
    s.accel_y = 16'sd8192;
    send_sample(s);
    stamp = stamp + 10;
    s = posed_sample(POSE_NEG_Z, stamp);
    s.accel_x = 16'sd2048;
    send_sample(s);
    stamp = stamp + 10;
    s = posed_sample(POSE_NEG_Z, stamp);
    s.accel_y = -16'sd2048;
    send_sample(s);
    stamp = stamp + 10;
    s = posed_sample(POSE_POS_X, stamp);
    s.accel_x = 16'sd8193;
    s.accel_y = -16'sd2047;
    s.accel_z = 16'sd2047;
    send_sample(s);
  endtask

  // Full-scale rotation on all axes, a rate just under and just over the
  // default limit, and the two undefined codes, which must leave the timer
  // alone: the final sample only reports a held pose if they did.
  task automatic test_motion_and_undefined_codes();
    sample_t           s;
    logic [TIME_W-1:0] restart;
    stamp = stamp + 1;
    s = posed_sample(POSE_POS_Z, stamp);
    s.rate_x = -16'sd32768;
    s.rate_y = -16'sd32768;
    s.rate_z = -16'sd32768;
    send_sample(s);
    stamp = stamp + DWELL_RST + 1;
    s = posed_sample(POSE_POS_Z, stamp);
    s.rate_x = 16'sd714;
    send_sample(s);
    stamp = stamp + 1;
    s = posed_sample(POSE_POS_Z, stamp);
    s.rate_x = 16'sd715;
    send_sample(s);
    restart = stamp;
    s = posed_sample(POSE_POS_Z, restart + 1000);
    s.target_pose = POSE_UNDEF_A;
    send_sample(s);
    s = posed_sample(POSE_POS_Z, restart + 2000);
    s.target_pose = POSE_UNDEF_B;
    send_sample(s);
    stamp = restart + DWELL_RST + 1;
    send_sample(posed_sample(POSE_POS_Z, stamp));
  endtask

  // The timer starts just below the top of the 48-bit range and the
  // timestamp wraps to a small value before the dwell expires.
  task automatic test_timestamp_wrap();
    sample_t s;
    stamp = '1 - 48'd9;
    s = posed_sample(POSE_POS_Z, stamp);
    s.accel_z = '0;
    send_sample(s);
    stamp = 48'd1999990;
    send_sample(posed_sample(POSE_POS_Z, stamp));
    stamp = 48'd1999991;
    send_sample(posed_sample(POSE_POS_Z, stamp));
  endtask

  task automatic test_random_at_reset_config();
    run_pose_sequences(200, 1000000);
  endtask

  // Every register at its largest value: the rate limit can never be
  // exceeded and the dwell needs steps in the billions of microseconds.
  task automatic test_wide_open_config();
    apply_config('1, '1, '1, '1);
    run_pose_sequences(120, 32'h7fff_ffff);
  endtask

  // Every register at zero: any rotation is too much, no pose can pass the
  // minor bound, and the dwell is zero.
  task automatic test_closed_config();
    apply_config('0, '0, '0, '0);
    run_pose_sequences(80, 2);
  endtask

  // A round limit so a rate can land exactly on it, and a very short dwell
  // so elapsed times equal to the dwell come up often.
  task automatic test_tight_limits();
    sample_t s;
    apply_config(32'd1000000, 15'd12000, 15'd1000, 32'd5);
    stamp = stamp + 10;
    s = posed_sample(POSE_POS_X, stamp);
    s.rate_x = 16'sd1000;
    send_sample(s);
    stamp = stamp + 10;
    s = posed_sample(POSE_POS_X, stamp);
    s.rate_x = -16'sd1000;
    s.rate_y = 16'sd1;
    send_sample(s);
    run_pose_sequences(300, 3);
  endtask

  // Neither side idles here, so back-to-back transfers hit every pipeline
  // stage at once.
  task automatic test_no_idle_stretch();
    apply_config(32'd2000000, 15'd4096, 15'd4096, 32'd1000);
    gaps_on = 1'b0;
    run_pose_sequences(150, 400);
    gaps_on = 1'b1;
  endtask

  // The result side stops for a long stretch while samples keep coming, so
  // the pipeline fills and must hold off the sender without losing anything.
  task automatic test_output_stall();
    gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    run_pose_sequences(60, 400);
    gaps_on = 1'b1;
  endtask

  task automatic test_back_to_defaults();
    apply_config(GYRO_LIMIT_RST, MAJOR_THR_RST, MINOR_THR_RST, DWELL_RST);
    run_pose_sequences(240, 1000000);
  endtask

  // Result-side ready, with random idle cycles and the long stalls that
  // test_output_stall asks for. The stall length is counted here alone.
  initial begin
    int          hold_left;
    int unsigned hold_served;
    hold_left = 0;
    hold_served = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !gaps_on || ($urandom_range(99) >= 26);
      end
    end
  end

  // At each edge: first compare a transferred result with the oldest
  // verdict, then work out the verdict for a sample transferred at the same
  // edge. Both handshakes are read before any of this edge's updates land.
  always @(posedge clk) begin
    sample_t seen;
    result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        verdict_errors++;
        if (verdict_errors <= MAX_REPORTS)
          $display("%0t: result with no sample waiting: pose_held %b moving %b",
                   $time, result_ch.pose_held, result_ch.moving);
      end else begin
        want = verdict_q.pop_front();
        if (result_ch.pose_held !== want.pose_held || result_ch.moving !== want.moving) begin
          verdict_errors++;
          if (verdict_errors <= MAX_REPORTS)
            $display("%0t: verdict mismatch: pose_held exp %b got %b, moving exp %b got %b",
                     $time, want.pose_held, result_ch.pose_held, want.moving,
                     result_ch.moving);
        end
      end
    end
    if (!rst && sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) begin
      seen.time_us = sample_ch.time_us;
      seen.accel_x = sample_ch.accel_x;
      seen.accel_y = sample_ch.accel_y;
      seen.accel_z = sample_ch.accel_z;
      seen.rate_x = sample_ch.rate_x;
      seen.rate_y = sample_ch.rate_y;
      seen.rate_z = sample_ch.rate_z;
      seen.target_pose = sample_ch.target_pose;
      verdict_q.push_back(judge_sample(seen));
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
      @(posedge clk);
    $display("tb_still_orientation_dwell_detector_top: FAIL");
    $finish;
  end

  // Test sequence. Reset is applied once; the directed tests and a first random
  // run use the default register values, then each later phase but the output stall
  // test reprograms the detector while it is idle and runs random pose sequences.
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_GYRO_LIMIT;
    cfg_data <= '0;
    sample_ch.valid <= 1'b0;
    drive_payload('0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_dwell_from_first_sample();
    test_each_pose_at_full_scale();
    test_threshold_edges();
    test_motion_and_undefined_codes();
    test_timestamp_wrap();
    test_random_at_reset_config();
    test_wide_open_config();
    test_closed_config();
    test_tight_limits();
    test_no_idle_stretch();
    test_output_stall();
    test_back_to_defaults();

    drain();
    if (verdict_errors == 0 && verdict_q.size() == 0) begin
      $display("tb_still_orientation_dwell_detector_top: PASS");
    end else begin
      $display("tb_still_orientation_dwell_detector_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== still_orientation_dwell_detector_top.f =====
hw/rtl/sodd_pkg.sv
hw/rtl/sodd_if.sv
hw/rtl/sodd_front.sv
hw/rtl/sodd_decide.sv
hw/rtl/still_orientation_dwell_detector_top.sv
dv/tb_still_orientation_dwell_detector_top.sv
